### design/assert_macros.svh
// Assertion macros shared by the sparse vector store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and reset.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_SYNC(lbl, prop, msg) \
   `ASSERT_CLK_RST(lbl, clock, reset, prop, msg)

`endif

### design/ssvs_pkg.sv
// Shared constants, codes and control/status types of the sparse vector store.
`timescale 1ns / 1ps

package ssvs_pkg;

   localparam int CAPACITY   = 1024;
   localparam int INDEX_BITS = 32;
   localparam int VALUE_BITS = 64;

   localparam int ADDR_BITS = $clog2(CAPACITY);
   localparam int POS_BITS  = $clog2(CAPACITY + 1);

   localparam int KEY_PORT_BITS   = 32;
   localparam int VALUE_PORT_BITS = 64;

   localparam int LEN_BITS = 33;
   localparam int CMP_BITS = (INDEX_BITS > LEN_BITS) ? INDEX_BITS : LEN_BITS;
   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(64'h1_0000_0000);

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_REG_SHIFT = 3;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - CSR_REG_SHIFT;
   localparam logic [CSR_IDX_BITS-1:0] REG_VECTOR_LENGTH = CSR_IDX_BITS'(0);

   localparam logic ACT_SET = 1'b0;
   localparam logic ACT_GET = 1'b1;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NO_VALUE = 2'd1,
      ST_RANGE    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic probe;
      logic compare;
      logic check;
      logic write_value;
      logic start_del;
      logic start_ins;
      logic shift;
      logic shift_end;
      logic emit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic range_bad;
      logic search_open;
      logic found;
      logic is_get;
      logic val_zero;
      logic full;
      logic shift_done;
   } stat_type;

endpackage

### design/ssvs_ctrl.sv
// Sequencer for lookup, update, tail shift and result hand-off.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssvs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ssvs_pkg::stat_type stat,
   output ssvs_pkg::cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PROBE = 6'b000010,
      S_CMP   = 6'b000100,
      S_CHECK = 6'b001000,
      S_SHIFT = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (stat.range_bad) begin
               state_in = S_DONE;
            end else begin
               cmd.probe = 1'b1;
               state_in  = stat.search_open ? S_CMP : S_CHECK;
            end
         end
         S_CMP: begin
            cmd.compare = 1'b1;
            state_in    = S_PROBE;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (!stat.is_get && stat.found && stat.val_zero) begin
               cmd.start_del = 1'b1;
               state_in      = S_SHIFT;
            end else if (!stat.is_get && !stat.found && !stat.val_zero && !stat.full) begin
               cmd.start_ins = 1'b1;
               state_in      = S_SHIFT;
            end else begin
               cmd.write_value = !stat.is_get && stat.found && !stat.val_zero;
               state_in        = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_done) begin
               cmd.shift_end = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_SYNC(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "result without finished item")
   `ASSERT_SYNC(a_shift_leads_done, (state_ff == S_SHIFT) && stat.shift_done |=> state_ff == S_DONE, "shift did not finish")

endmodule

### design/ssvs_dp.sv
// Table memories, binary search registers, shift pointer and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ssvs_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ssvs_pkg::cmd_type                     cmd,
   output ssvs_pkg::stat_type                    stat,
   input  logic [ssvs_pkg::LEN_BITS-1:0]         vector_length,
   input  logic                                  req_action,
   input  logic [ssvs_pkg::KEY_PORT_BITS-1:0]    req_element_index,
   input  logic [ssvs_pkg::VALUE_PORT_BITS-1:0]  req_element_value,
   output logic [1:0]                            rsp_status,
   output logic [ssvs_pkg::VALUE_PORT_BITS-1:0]  rsp_read_value,
   output logic [ssvs_pkg::POS_BITS-1:0]         rsp_position,
   output logic [ssvs_pkg::POS_BITS-1:0]         rsp_stored_count
);

   localparam int AB = ssvs_pkg::ADDR_BITS;
   localparam int PB = ssvs_pkg::POS_BITS;
   localparam int IB = ssvs_pkg::INDEX_BITS;
   localparam int VB = ssvs_pkg::VALUE_BITS;

   logic [IB-1:0] index_store [ssvs_pkg::CAPACITY];
   logic [VB-1:0] value_store [ssvs_pkg::CAPACITY];

   // request
   logic [IB-1:0] key_ff;
   logic [VB-1:0] val_ff;
   logic          act_ff;
   logic          range_bad_ff;
   logic [IB-1:0] key_in;

   // search / shift
   logic [PB-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, mid;
   logic [PB-1:0] count_ff, count_in;
   logic [PB-1:0] slot_ff, slot_in;
   logic [PB-1:0] ptr_ff, ptr_in;
   logic [AB-1:0] dst_ff, dst_in;
   logic          pend_ff, pend_in;
   logic          ins_ff, ins_in;
   logic          more;

   // memory ports
   logic          rd_en, idx_we, val_we;
   logic [AB-1:0] rd_addr, wr_addr;
   logic [IB-1:0] wr_idx;
   logic [VB-1:0] wr_val;
   logic [IB-1:0] idx_rd_ff;
   logic [VB-1:0] val_rd_ff;

   // result
   ssvs_pkg::status_type status_ff, status_in;
   logic [VB-1:0]        read_ff, read_in;
   ssvs_pkg::status_type rsp_status_ff;
   logic [VB-1:0]        rsp_read_ff;
   logic [PB-1:0]        rsp_pos_ff, rsp_count_ff;

   assign key_in = IB'(req_element_index);
   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign more   = ins_ff ? (ptr_ff > slot_ff) : (ptr_ff < count_ff);

   always_comb begin
      stat.range_bad   = range_bad_ff;
      stat.search_open = lo_ff < hi_ff;
      stat.found       = (lo_ff < count_ff) && (idx_rd_ff == key_ff);
      stat.is_get      = (act_ff == ssvs_pkg::ACT_GET);
      stat.val_zero    = (val_ff == '0);
      stat.full        = (count_ff == PB'(ssvs_pkg::CAPACITY));
      stat.shift_done  = !more && !pend_ff;
   end

   // read port
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = lo_ff[AB-1:0];
      if (cmd.probe) begin
         rd_en   = 1'b1;
         rd_addr = stat.search_open ? mid[AB-1:0] : lo_ff[AB-1:0];
      end else if (cmd.shift && more) begin
         rd_en   = 1'b1;
         rd_addr = ins_ff ? AB'(ptr_ff - 1'b1) : ptr_ff[AB-1:0];
      end
   end

   // write port
   always_comb begin
      idx_we  = 1'b0;
      val_we  = 1'b0;
      wr_addr = lo_ff[AB-1:0];
      wr_idx  = key_ff;
      wr_val  = val_ff;
      if (cmd.write_value) begin
         val_we = 1'b1;
      end else if (cmd.shift && pend_ff) begin
         idx_we  = 1'b1;
         val_we  = 1'b1;
         wr_addr = dst_ff;
         wr_idx  = idx_rd_ff;
         wr_val  = val_rd_ff;
      end else if (cmd.shift_end && ins_ff) begin
         idx_we  = 1'b1;
         val_we  = 1'b1;
         wr_addr = slot_ff[AB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (idx_we) begin
         index_store[wr_addr] <= wr_idx;
      end
      if (val_we) begin
         value_store[wr_addr] <= wr_val;
      end
      if (rd_en) begin
         idx_rd_ff <= index_store[rd_addr];
         val_rd_ff <= value_store[rd_addr];
      end
   end

   always_comb begin
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      slot_in   = slot_ff;
      ptr_in    = ptr_ff;
      dst_in    = dst_ff;
      pend_in   = pend_ff;
      ins_in    = ins_ff;
      count_in  = count_ff;
      status_in = status_ff;
      read_in   = read_ff;
      if (cmd.load) begin
         lo_in     = '0;
         hi_in     = count_ff;
         slot_in   = '0;
         read_in   = '0;
         status_in = (ssvs_pkg::CMP_BITS'(key_in) >= ssvs_pkg::CMP_BITS'(vector_length)) ?
                     ssvs_pkg::ST_RANGE : ssvs_pkg::ST_OK;
      end
      if (cmd.probe) begin
         mid_in = mid;
      end
      if (cmd.compare) begin
         if (idx_rd_ff < key_ff) begin
            lo_in = PB'(mid_ff + 1'b1);
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.check) begin
         slot_in = lo_ff;
         read_in = (stat.is_get && stat.found) ? val_rd_ff : '0;
         if (stat.is_get && !stat.found) begin
            status_in = ssvs_pkg::ST_NO_VALUE;
         end else if (!stat.is_get && !stat.found && !stat.val_zero && stat.full) begin
            status_in = ssvs_pkg::ST_FULL;
         end else begin
            status_in = ssvs_pkg::ST_OK;
         end
      end
      if (cmd.start_del) begin
         ins_in  = 1'b0;
         ptr_in  = PB'(lo_ff + 1'b1);
         pend_in = 1'b0;
      end
      if (cmd.start_ins) begin
         ins_in  = 1'b1;
         ptr_in  = count_ff;
         pend_in = 1'b0;
      end
      if (cmd.shift) begin
         pend_in = more;
         if (more) begin
            dst_in = ins_ff ? ptr_ff[AB-1:0] : AB'(ptr_ff - 1'b1);
            ptr_in = ins_ff ? PB'(ptr_ff - 1'b1) : PB'(ptr_ff + 1'b1);
         end
      end
      if (cmd.shift_end) begin
         count_in = ins_ff ? PB'(count_ff + 1'b1) : PB'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff       <= key_in;
         val_ff       <= VB'(req_element_value);
         act_ff       <= req_action;
         range_bad_ff <= (ssvs_pkg::CMP_BITS'(key_in) >=
                          ssvs_pkg::CMP_BITS'(vector_length));
      end
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      slot_ff   <= slot_in;
      ptr_ff    <= ptr_in;
      dst_ff    <= dst_in;
      ins_ff    <= ins_in;
      status_ff <= status_in;
      read_ff   <= read_in;
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_read_ff   <= read_ff;
         rsp_pos_ff    <= slot_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_read_value   = ssvs_pkg::VALUE_PORT_BITS'(rsp_read_ff);
   assign rsp_position     = rsp_pos_ff;
   assign rsp_stored_count = rsp_count_ff;

   `ASSERT_SYNC(a_count_bound, count_ff <= PB'(ssvs_pkg::CAPACITY), "entry count above capacity")
   `ASSERT_SYNC(a_count_step, !$past(reset) |-> (count_ff == $past(count_ff) || count_ff == PB'($past(count_ff) + 1'b1) || count_ff == PB'($past(count_ff) - 1'b1)), "entry count jumped")
   `ASSERT_SYNC(a_search_window, cmd.compare |-> lo_ff < hi_ff, "compare on empty search window")
   `ASSERT_SYNC(a_no_insert_full, cmd.start_ins |-> count_ff < PB'(ssvs_pkg::CAPACITY), "insert started on full table")

endmodule

### design/sorted_sparse_vector_store.sv
// Top level of the sorted sparse vector store: CSR, sequencer and datapath.
`timescale 1ns / 1ps
// Sequence: a get or update runs a binary search, each step a probe read and then a
//   compare; insert/delete then shift the tail, one entry per cycle.
// An out-of-range index skips the search. Throughput: one item at a time.
// The next beat is accepted while the previous result beat still waits in the output reg.
// Reset (sync, active high): count 0, vector_length 2^32, no clearing pass (tables
//   are only used below the count).

module sorted_sparse_vector_store (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_action,
   input  logic [ssvs_pkg::KEY_PORT_BITS-1:0]    req_element_index,
   input  logic [ssvs_pkg::VALUE_PORT_BITS-1:0]  req_element_value,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [1:0]                            rsp_status,
   output logic [ssvs_pkg::VALUE_PORT_BITS-1:0]  rsp_read_value,
   output logic [ssvs_pkg::POS_BITS-1:0]         rsp_position,
   output logic [ssvs_pkg::POS_BITS-1:0]         rsp_stored_count,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [ssvs_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [ssvs_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [ssvs_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   ssvs_pkg::cmd_type  cmd;
   ssvs_pkg::stat_type stat;

   // vector_length register: 33 bits, so registers sit on 8-byte strides
   logic [ssvs_pkg::LEN_BITS-1:0]     vector_length_ff, vector_length_in;
   logic [ssvs_pkg::CSR_IDX_BITS-1:0] csr_idx;
   logic                              csr_wr;

   assign csr_idx    = csr_paddr[ssvs_pkg::CSR_ADDR_BITS-1:ssvs_pkg::CSR_REG_SHIFT];
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      vector_length_in = vector_length_ff;
      if (csr_wr && (csr_idx == ssvs_pkg::REG_VECTOR_LENGTH)) begin
         vector_length_in = csr_pwdata[ssvs_pkg::LEN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vector_length_ff <= ssvs_pkg::LEN_RESET;
      end else begin
         vector_length_ff <= vector_length_in;
      end
   end

   // unmapped addresses read as zero
   assign csr_prdata = (csr_idx == ssvs_pkg::REG_VECTOR_LENGTH) ?
                       ssvs_pkg::CSR_DATA_BITS'(vector_length_ff) : '0;

   // sequencer: accepts a beat only when idle, holds the result beat
   ssvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, search window, shift pipeline and result payload
   ssvs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .vector_length     (vector_length_ff),
      .req_action        (req_action),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_position      (rsp_position),
      .rsp_stored_count  (rsp_stored_count)
   );

endmodule

### sim/sorted_sparse_vector_store_tb.sv
// Self-checking testbench for the sorted sparse vector store.
`timescale 1ns / 1ps

module sorted_sparse_vector_store_tb;

   // Expected response beat, in port widths.
   typedef struct packed {
      ssvs_pkg::status_type             status;
      logic [63:0]                      read_value;
      logic [ssvs_pkg::POS_BITS-1:0]    position;
      logic [ssvs_pkg::POS_BITS-1:0]    stored_count;
   } outcome_type;

   // One line of the directed plan: either a length write or a request beat.
   // Rows marked known carry an expectation typed in by hand.
   typedef struct {
      bit                               set_span;
      bit [ssvs_pkg::LEN_BITS-1:0]      span;
      logic                             act;
      bit [31:0]                        key;
      bit [63:0]                        val;
      bit                               known;
      outcome_type                      want;
   } plan_row_type;

   localparam bit [ssvs_pkg::LEN_BITS-1:0] FULL_SPAN = ssvs_pkg::LEN_BITS'(64'h1_0000_0000);
   localparam bit [31:0]                   FILL_BASE = 32'hF000_0000;

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_stall;
   logic                                   req_action;
   logic [ssvs_pkg::KEY_PORT_BITS-1:0]     req_element_index;
   logic [ssvs_pkg::VALUE_PORT_BITS-1:0]   req_element_value;
   logic                                   rsp_valid;
   logic                                   rsp_stall;
   logic [1:0]                             rsp_status;
   logic [ssvs_pkg::VALUE_PORT_BITS-1:0]   rsp_read_value;
   logic [ssvs_pkg::POS_BITS-1:0]          rsp_position;
   logic [ssvs_pkg::POS_BITS-1:0]          rsp_stored_count;
   logic                                   csr_psel;
   logic                                   csr_penable;
   logic                                   csr_pwrite;
   logic [ssvs_pkg::CSR_ADDR_BITS-1:0]     csr_paddr;
   logic [ssvs_pkg::CSR_DATA_BITS-1:0]     csr_pwdata;
   logic [ssvs_pkg::CSR_DATA_BITS-1:0]     csr_prdata;
   logic                                   csr_pready;

   // Shadow of the block: sorted keys, values, occupancy and vector length.
   bit [31:0]                     key_table [ssvs_pkg::CAPACITY];
   bit [63:0]                     value_table [ssvs_pkg::CAPACITY];
   int                            occupancy;
   bit [ssvs_pkg::LEN_BITS-1:0]   vector_span;

   outcome_type         pending_results [$];
   plan_row_type        plan [$];

   int   error_count;
   int   beat_total;
   int   range_total;
   int   miss_total;
   int   full_total;
   int   span_writes;
   int   peak_occupancy;
   int   cycle_total;
   int   hold_request;
   bit   quiet;

   sorted_sparse_vector_store i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_read_value    (rsp_read_value),
      .rsp_position      (rsp_position),
      .rsp_stored_count  (rsp_stored_count),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop in case the block hangs; far beyond the slowest legal run.
   initial begin
      #(50_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor: lower-bound search over the shadow table, then read, update,
   // delete with tail shift down, or insert with tail shift up.
   // ---------------------------------------------------------------------
   function automatic outcome_type apply_request(logic act, bit [31:0] key, bit [63:0] val);
      outcome_type res;
      int          lo;
      int          hi;
      int          mid;
      bit          hit;
      res.status     = ssvs_pkg::ST_OK;
      res.read_value = '0;
      lo = 0;
      hi = occupancy;
      if ({1'b0, key} >= vector_span) begin
         res.status = ssvs_pkg::ST_RANGE;   // position stays 0, table untouched
      end else begin
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (key_table[mid] < key) lo = mid + 1;
            else hi = mid;
         end
         hit = (lo < occupancy) && (key_table[lo] == key);
         if (act == ssvs_pkg::ACT_GET) begin
            if (hit) res.read_value = value_table[lo];
            else res.status = ssvs_pkg::ST_NO_VALUE;
         end else if (hit) begin
            if (val != 0) begin
               value_table[lo] = val;
            end else begin
               for (int i = lo; i < occupancy - 1; i++) begin
                  key_table[i]   = key_table[i + 1];
                  value_table[i] = value_table[i + 1];
               end
               occupancy--;
            end
         end else if (val != 0) begin
            if (occupancy >= ssvs_pkg::CAPACITY) begin
               res.status = ssvs_pkg::ST_FULL;
            end else begin
               for (int i = occupancy; i > lo; i--) begin
                  key_table[i]   = key_table[i - 1];
                  value_table[i] = value_table[i - 1];
               end
               key_table[lo]   = key;
               value_table[lo] = val;
               occupancy++;
            end
         end
      end
      res.position     = ssvs_pkg::POS_BITS'(lo);
      res.stored_count = ssvs_pkg::POS_BITS'(occupancy);
      return res;
   endfunction

   // Value mix: zero (delete), all ones, or fully random.
   function automatic bit [63:0] random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 20) return 64'h0;
      if (pick < 28) return '1;
      return {$urandom, $urandom};
   endfunction

   // Half the time an index already stored (sometimes its neighbor), else random.
   function automatic bit [31:0] pick_key();
      bit [31:0] key;
      if (occupancy > 0 && $urandom_range(0, 1) == 1) begin
         key = key_table[$urandom_range(0, occupancy - 1)];
         if ($urandom_range(0, 4) == 0) key = key + 1;
      end else begin
         key = $urandom;
      end
      return key;
   endfunction

   function automatic plan_row_type beat_row(logic act, bit [31:0] key, bit [63:0] val);
      plan_row_type row;
      row = '{default: '0};
      row.act = act;
      row.key = key;
      row.val = val;
      return row;
   endfunction

   function automatic plan_row_type known_row(logic act, bit [31:0] key, bit [63:0] val,
                                              ssvs_pkg::status_type st, bit [63:0] rd,
                                              int pos, int cnt);
      plan_row_type row;
      row = beat_row(act, key, val);
      row.known = 1'b1;
      row.want.status       = st;
      row.want.read_value   = rd;
      row.want.position     = ssvs_pkg::POS_BITS'(pos);
      row.want.stored_count = ssvs_pkg::POS_BITS'(cnt);
      return row;
   endfunction

   function automatic plan_row_type span_row(bit [ssvs_pkg::LEN_BITS-1:0] span);
      plan_row_type row;
      row = '{default: '0};
      row.set_span = 1'b1;
      row.span     = span;
      return row;
   endfunction

   // ---------------------------------------------------------------------
   // Request side. Entered and left at a falling edge; valid stays high
   // into the next call unless a gap is drawn, so back-to-back beats are
   // possible. Random gaps are skipped in calm stretches and the quiet tail.
   // ---------------------------------------------------------------------
   task automatic offer_request(input logic act, input bit [31:0] key, input bit [63:0] val,
                                input bit known, input outcome_type want);
      outcome_type predicted;
      int          gap;
      gap = 0;
      if (!quiet && ((beat_total / 37) % 4 != 3) && $urandom_range(0, 99) < 20)
         gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_element_index <= key;
      req_element_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_request(act, key, val);
      pending_results.push_back(known ? want : predicted);
      beat_total++;
      if (predicted.status == ssvs_pkg::ST_RANGE) range_total++;
      if (predicted.status == ssvs_pkg::ST_NO_VALUE) miss_total++;
      if (predicted.status == ssvs_pkg::ST_FULL) full_total++;
      if (occupancy > peak_occupancy) peak_occupancy = occupancy;
      @(negedge clock);
   endtask

   // Sender holds off until every outstanding response has been checked.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Register write (setup + access), then read back over the same port.
   task automatic write_span(input bit [ssvs_pkg::LEN_BITS-1:0] span);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ssvs_pkg::CSR_ADDR_BITS'(ssvs_pkg::REG_VECTOR_LENGTH)
                     << ssvs_pkg::CSR_REG_SHIFT;
      csr_pwdata  <= ssvs_pkg::CSR_DATA_BITS'(span);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      vector_span = span;
      span_writes++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[ssvs_pkg::LEN_BITS-1:0] !== span) begin
         $error("vector_length readback: expected %0h, got %0h", span,
                csr_prdata[ssvs_pkg::LEN_BITS-1:0]);
         error_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Short vectors: dense collisions on few keys, plus boundary and wild indices.
   task automatic run_short_span(input int beats, input bit [ssvs_pkg::LEN_BITS-1:0] span);
      bit [31:0] key;
      int        pick;
      write_span(span);
      repeat (beats) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) key = $urandom_range(0, 32'(span - 1));
         else if (pick < 85) key = $urandom;
         else if (pick < 93) key = 32'(span);
         else key = 32'(span - 1);
         offer_request(($urandom_range(0, 99) < 35) ? ssvs_pkg::ACT_GET : ssvs_pkg::ACT_SET,
                       key, random_word(), 1'b0, '0);
      end
   endtask

   // Sets, some followed by a read of the same key, and reads, on stored, nearby or random keys.
   task automatic run_mixed(input int beats, input bit [ssvs_pkg::LEN_BITS-1:0] span,
                            input int quiet_tail);
      bit [31:0] key;
      int        sent;
      write_span(span);
      sent = 0;
      while (sent < beats) begin
         if (sent >= beats - quiet_tail) quiet = 1'b1;
         key = pick_key();
         if ($urandom_range(0, 99) < 30) begin
            offer_request(ssvs_pkg::ACT_GET, key, {$urandom, $urandom}, 1'b0, '0);
            sent++;
         end else begin
            offer_request(ssvs_pkg::ACT_SET, key, random_word(), 1'b0, '0);
            sent++;
            if ($urandom_range(0, 99) < 40) begin
               offer_request(ssvs_pkg::ACT_GET, key, {$urandom, $urandom}, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stall bursts, calm windows, and a long hold-off
   // on request from the stimulus thread (counted here, cycle by cycle).
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         cycle_total++;
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && !quiet && ((cycle_total / 257) % 4 != 2) &&
                      $urandom_range(0, 99) < 10) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker: in order against the oldest expectation, every field.
   always @(posedge clock) begin : rsp_check
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("response beat with nothing outstanding: status %0d", rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %0h, got %0h", want.read_value, rsp_read_value);
               error_count++;
            end
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, got %0d", want.position, rsp_position);
               error_count++;
            end
            if (rsp_stored_count !== want.stored_count) begin
               $error("stored_count: expected %0d, got %0d", want.stored_count,
                      rsp_stored_count);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ssvs_pkg::ACT_SET;
      req_element_index = '0;
      req_element_value = '0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      occupancy         = 0;
      vector_span       = ssvs_pkg::LEN_RESET;
      error_count       = 0;
      beat_total        = 0;
      range_total       = 0;
      miss_total        = 0;
      full_total        = 0;
      span_writes       = 0;
      peak_occupancy    = 0;
      cycle_total       = 0;
      hold_request      = 0;
      quiet             = 1'b0;

      // Directed: empty table, index and value extremes, update, delete,
      // absent-with-zero, range edge, zero and one vector length.
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'h0, 64'h0, ssvs_pkg::ST_NO_VALUE,
                               64'h0, 0, 0));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'h0, 64'h0, ssvs_pkg::ST_OK,
                               64'h0, 0, 0));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'hFFFF_FFFF, '1, ssvs_pkg::ST_OK,
                               64'h0, 0, 1));
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'hFFFF_FFFF, 64'h0, ssvs_pkg::ST_OK,
                               '1, 0, 1));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'h0, 64'h1, ssvs_pkg::ST_OK,
                               64'h0, 0, 2));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'h5, 64'h8000_0000_0000_0000,
                               ssvs_pkg::ST_OK, 64'h0, 1, 3));
      plan.push_back(beat_row(ssvs_pkg::ACT_SET, 32'h5, 64'h0123_4567_89AB_CDEF));
      plan.push_back(beat_row(ssvs_pkg::ACT_GET, 32'h5, '1));
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'h4, 64'h0, ssvs_pkg::ST_NO_VALUE,
                               64'h0, 1, 3));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'h5, 64'h0, ssvs_pkg::ST_OK,
                               64'h0, 1, 2));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'h0, 64'h0, ssvs_pkg::ST_OK,
                               64'h0, 0, 1));
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'h0, 64'h0, ssvs_pkg::ST_NO_VALUE,
                               64'h0, 0, 1));
      plan.push_back(beat_row(ssvs_pkg::ACT_SET, 32'h7FFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA));
      plan.push_back(beat_row(ssvs_pkg::ACT_SET, 32'h8000_0000, 64'h5555_5555_5555_5555));
      plan.push_back(beat_row(ssvs_pkg::ACT_GET, 32'h8000_0000, 64'h0));
      plan.push_back(span_row(ssvs_pkg::LEN_BITS'(16)));
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'd16, 64'h0, ssvs_pkg::ST_RANGE,
                               64'h0, 0, 3));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'hFFFF_FFFF, 64'h0, ssvs_pkg::ST_RANGE,
                               64'h0, 0, 3));
      plan.push_back(beat_row(ssvs_pkg::ACT_SET, 32'd15, 64'h1));
      plan.push_back(beat_row(ssvs_pkg::ACT_GET, 32'd15, 64'h0));
      plan.push_back(span_row(ssvs_pkg::LEN_BITS'(0)));
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'h0, 64'h0, ssvs_pkg::ST_RANGE,
                               64'h0, 0, 4));
      plan.push_back(known_row(ssvs_pkg::ACT_SET, 32'h0, 64'h2, ssvs_pkg::ST_RANGE,
                               64'h0, 0, 4));
      plan.push_back(span_row(ssvs_pkg::LEN_BITS'(1)));
      plan.push_back(beat_row(ssvs_pkg::ACT_SET, 32'h0, 64'h7));
      plan.push_back(known_row(ssvs_pkg::ACT_GET, 32'h1, 64'h0, ssvs_pkg::ST_RANGE,
                               64'h0, 0, 5));
      plan.push_back(beat_row(ssvs_pkg::ACT_GET, 32'h0, 64'h0));
      plan.push_back(span_row(FULL_SPAN));
      plan.push_back(beat_row(ssvs_pkg::ACT_GET, 32'hFFFF_FFFF, 64'h0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].set_span) write_span(plan[i].span);
         else offer_request(plan[i].act, plan[i].key, plan[i].val, plan[i].known,
                            plan[i].want);
      end

      // Small vectors, including the one-element vector.
      run_short_span(50, ssvs_pkg::LEN_BITS'($urandom_range(2, 16)));
      run_short_span(50, ssvs_pkg::LEN_BITS'($urandom_range(17, 64)));
      run_short_span(30, ssvs_pkg::LEN_BITS'(1));
      run_short_span(70, ssvs_pkg::LEN_BITS'($urandom_range(32, 64)));

      // Build up the table with ascending keys near the top (short tails).
      // Response side holds off at the start so the block backs up.
      write_span(FULL_SPAN);
      hold_request = 400;
      for (int n = 0; n < 160; n++)
         offer_request(ssvs_pkg::ACT_SET, FILL_BASE + 32'(n), {$urandom, $urandom} | 64'h1,
                       1'b0, '0);

      // Grown table: insert below the block, updates, deletes at both ends,
      // and a miss past the last entry so position reaches the count.
      offer_request(ssvs_pkg::ACT_SET, 32'hEFFF_FFFF, 64'h1, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_SET, 32'h0000_0003, 64'h0, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_GET, FILL_BASE, 64'h0, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_SET, FILL_BASE, '1, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_SET, 32'hFFFF_FFFF, 64'h0, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_SET, 32'hFFFF_FFFE, 64'h3, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_GET, 32'hFFFF_FFFF, 64'h0, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_SET, 32'hFFFF_FFFF, 64'h9, 1'b0, '0);
      offer_request(ssvs_pkg::ACT_SET, key_table[0], 64'h0, 1'b0, '0);
      repeat (6) offer_request(ssvs_pkg::ACT_SET, $urandom, {$urandom, $urandom} | 64'h1,
                               1'b0, '0);

      // Mixed traffic on the big table; middle stretch shortens the vector
      // so stored keys above the new length come back out of range.
      run_mixed(70, FULL_SPAN, 0);
      run_mixed(55, ssvs_pkg::LEN_BITS'({1'b0, 1'b1, 31'($urandom)}), 0);
      run_mixed(55, FULL_SPAN, 30);

      wait_drained();
      repeat (1100) @(posedge clock);

      $display("Run covered %0d requests over %0d length settings: %0d out of range, %0d misses,",
               beat_total, span_writes, range_total, miss_total);
      $display("%0d refused on a full table; occupancy peaked at %0d of %0d.",
               full_total, peak_occupancy, ssvs_pkg::CAPACITY);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### sorted_sparse_vector_store.f
+incdir+design
design/ssvs_pkg.sv
design/ssvs_ctrl.sv
design/ssvs_dp.sv
design/sorted_sparse_vector_store.sv
sim/sorted_sparse_vector_store_tb.sv
